// File: hw/rtl/owd_pkg.sv
// Shared types, constants and helpers for the oversampled waveshaper block.
package owd_pkg;

  localparam int CHANNELS   = 4;
  localparam int OVERSAMPLE = 4;
  localparam int SAMPLE_W   = 24;
  localparam int CFG_W      = 32;
  localparam int IDX_W      = 3;

  localparam logic signed [31:0] DEC_Q30 = 32'sd154981283;
  localparam logic signed [31:0] ENC_Q30 = 32'sd929887697;

  localparam logic [IDX_W-1:0] REG_EDGE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LP_B0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_LP_A1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_LP_A2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_BP_B0 = 3'd4;
  localparam logic [IDX_W-1:0] REG_BP_A1 = 3'd5;
  localparam logic [IDX_W-1:0] REG_BP_A2 = 3'd6;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,  // decode channel into the filter input
    OP_LP_Y    = 4'd2,
    OP_LP_Z0   = 4'd3,
    OP_LP_Z1   = 4'd4,
    OP_SH_MUL  = 4'd5,  // waveshaper numerator and denominator
    OP_SH_DIV  = 4'd6,  // one quotient bit
    OP_SH_END  = 4'd7,
    OP_BP_Y    = 4'd8,
    OP_BP_Z0   = 4'd9,
    OP_BP_Z1   = 4'd10,
    OP_ENC     = 4'd11, // one encode component
    OP_DONE    = 4'd12
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] chan;
    logic       first;  // oversample step zero
    logic [1:0] pass;   // waveshaper pass
    logic [1:0] comp;   // encode component
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

  function automatic logic signed [63:0] sat64(input logic signed [79:0] v, input int bits);
    logic signed [79:0] lim;
    begin
      lim = 80'sd1 <<< (bits - 1);
      if (v > lim - 80'sd1) sat64 = 64'(lim - 80'sd1);
      else if (v < -lim) sat64 = 64'(-lim);
      else sat64 = 64'(v);
    end
  endfunction

  function automatic logic signed [79:0] rnd30(input logic signed [79:0] v);
    rnd30 = (v + (80'sd1 <<< 29)) >>> 30;
  endfunction

endpackage

// File: hw/rtl/owd_ctrl.sv
// Sequencer for decode, filter, waveshaper and encode steps.
module owd_ctrl #(
  parameter int OVERSAMPLE = owd_pkg::OVERSAMPLE
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  owd_pkg::stat_t stat,
  output owd_pkg::cmd_t  cmd
);
  localparam int OS_W = $clog2(OVERSAMPLE);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_LP   = 8'b00000010,
    S_SH   = 8'b00000100,
    S_DIV  = 8'b00001000,
    S_BP   = 8'b00010000,
    S_ENC  = 8'b00100000,
    S_OUT  = 8'b01000000,
    S_LOAD = 8'b10000000
  } state_t;

  state_t          state, state_next;
  logic [1:0]      sub, sub_next;
  logic [1:0]      chan, chan_next;
  logic [OS_W-1:0] step, step_next;
  logic [1:0]      pass, pass_next;
  logic            full, full_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sub <= '0;
      chan <= '0;
      step <= '0;
      pass <= '0;
      full <= 1'b0;
    end else begin
      state <= state_next;
      sub <= sub_next;
      chan <= chan_next;
      step <= step_next;
      pass <= pass_next;
      full <= full_next;
    end
  end

  always_comb begin
    state_next = state;
    sub_next = sub;
    chan_next = chan;
    step_next = step;
    pass_next = pass;
    full_next = full && out_stall;
    cmd.op = owd_pkg::OP_NONE;
    cmd.chan = chan;
    cmd.first = (step == '0);
    cmd.pass = pass;
    cmd.comp = sub;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = S_LOAD;
          chan_next = '0;
        end
      end
      S_LOAD: begin
        cmd.op = owd_pkg::OP_LOAD;
        state_next = S_LP;
        sub_next = '0;
        step_next = '0;
      end
      S_LP: begin
        case (sub)
          2'd0: cmd.op = owd_pkg::OP_LP_Y;
          2'd1: cmd.op = owd_pkg::OP_LP_Z0;
          default: cmd.op = owd_pkg::OP_LP_Z1;
        endcase
        sub_next = sub + 2'd1;
        if (sub == 2'd2) begin
          sub_next = '0;
          pass_next = '0;
          state_next = S_SH;
        end
      end
      S_SH: begin
        cmd.op = owd_pkg::OP_SH_MUL;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = owd_pkg::OP_SH_DIV;
        if (stat.div_last) begin
          cmd.op = owd_pkg::OP_SH_END;
          if (pass == 2'd2) state_next = S_BP;
          else begin
            pass_next = pass + 2'd1;
            state_next = S_SH;
          end
        end
      end
      S_BP: begin
        case (sub)
          2'd0: cmd.op = owd_pkg::OP_BP_Y;
          2'd1: cmd.op = owd_pkg::OP_BP_Z0;
          default: cmd.op = owd_pkg::OP_BP_Z1;
        endcase
        sub_next = sub + 2'd1;
        if (sub == 2'd2) begin
          sub_next = '0;
          if (step == OS_W'(OVERSAMPLE - 1)) begin
            step_next = '0;
            if (chan == 2'd3) state_next = S_ENC;
            else begin
              chan_next = chan + 2'd1;
              state_next = S_LOAD;
            end
          end else begin
            step_next = step + OS_W'(1);
            state_next = S_LP;
          end
        end
      end
      S_ENC: begin
        cmd.op = owd_pkg::OP_ENC;
        sub_next = sub + 2'd1;
        if (sub == 2'd3) begin
          sub_next = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // wait here while the previous result is still held
        if (!full || !out_stall) begin
          cmd.op = owd_pkg::OP_DONE;
          full_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/owd_dp.sv
// Datapath: decode, biquads, waveshaper divider, encode and coefficients.
module owd_dp #(
  parameter int OVERSAMPLE = owd_pkg::OVERSAMPLE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [owd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [owd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_take,
  input  logic signed [owd_pkg::SAMPLE_W-1:0] in_w,
  input  logic signed [owd_pkg::SAMPLE_W-1:0] in_y,
  input  logic signed [owd_pkg::SAMPLE_W-1:0] in_z,
  input  logic signed [owd_pkg::SAMPLE_W-1:0] in_x,
  input  owd_pkg::cmd_t                  cmd,
  output owd_pkg::stat_t                 stat,
  output logic signed [owd_pkg::SAMPLE_W-1:0] out_w,
  output logic signed [owd_pkg::SAMPLE_W-1:0] out_y,
  output logic signed [owd_pkg::SAMPLE_W-1:0] out_z,
  output logic signed [owd_pkg::SAMPLE_W-1:0] out_x
);
  logic [23:0]        edge_k;
  logic [30:0]        lp_b0, bp_b0;
  logic signed [31:0] lp_a1, lp_a2, bp_a1, bp_a2;

  logic signed [23:0] rw, ry, rz, rx;
  logic signed [39:0] lpd [8];
  logic signed [39:0] bpd [8];
  logic signed [31:0] xin;   // decoded channel input; bandpass output after OP_BP_Y
  logic signed [31:0] lpx;   // lowpass input: zero after oversample step zero
  logic signed [31:0] yv;    // current filter output / shaper value
  logic signed [31:0] kept [4];
  logic signed [23:0] res [4];

  // waveshaper divider
  logic               sneg;
  logic [71:0]        rem;
  logic [45:0]        den;
  logic [42:0]        quo;
  logic [6:0]         bitn;
  logic [6:0]         bidx;
  logic [71:0]        p_num;

  logic signed [79:0] p0, p1, sum;
  logic [2:0]         di;
  logic signed [31:0] sv, sgn;
  logic [31:0]        mag;
  logic [72:0]        trial;
  logic signed [31:0] shv;
  logic signed [79:0] s0, s1, s2, s3;

  assign di = {cmd.chan, 1'b0};
  assign lpx = cmd.first ? xin : '0;
  assign bidx = bitn - 7'd1;
  assign stat.div_last = (bitn == 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_k <= '0; lp_b0 <= '0; lp_a1 <= '0; lp_a2 <= '0;
      bp_b0 <= '0; bp_a1 <= '0; bp_a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        owd_pkg::REG_EDGE:  edge_k <= cfg_data[23:0];
        owd_pkg::REG_LP_B0: lp_b0 <= cfg_data[30:0];
        owd_pkg::REG_LP_A1: lp_a1 <= cfg_data;
        owd_pkg::REG_LP_A2: lp_a2 <= cfg_data;
        owd_pkg::REG_BP_B0: bp_b0 <= cfg_data[30:0];
        owd_pkg::REG_BP_A1: bp_a1 <= cfg_data;
        owd_pkg::REG_BP_A2: bp_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode gain applied with oversample gain, rounded to Q.23.
  always_comb begin
    s0 = 80'(rw) <<< 28;
    case (cmd.chan)
      2'd0: s1 = 80'(ry) + 80'(rz) + 80'(rx);
      2'd1: s1 = -80'(ry) - 80'(rz) + 80'(rx);
      2'd2: s1 = 80'(ry) - 80'(rz) - 80'(rx);
      default: s1 = -80'(ry) + 80'(rz) - 80'(rx);
    endcase
    s2 = (s0 + s1 * 80'(owd_pkg::DEC_Q30)) * 80'(OVERSAMPLE);
    s3 = owd_pkg::rnd30(s2);
  end

  // Shared multiply-accumulate for biquad steps and encode.
  always_comb begin
    p0 = '0; p1 = '0; sum = '0;
    case (cmd.op)
      owd_pkg::OP_LP_Y: begin
        p0 = 80'(lpx) * 80'($signed({1'b0, lp_b0}));
        sum = 80'(owd_pkg::sat64(owd_pkg::rnd30(p0) + 80'(lpd[di]), 32));
      end
      owd_pkg::OP_LP_Z0: begin
        p0 = 80'(lpx) * 80'($signed({1'b0, lp_b0, 1'b0}));
        p1 = 80'(yv) * 80'(lp_a1);
        sum = 80'(owd_pkg::sat64(owd_pkg::rnd30(p0 - p1) + 80'(lpd[di+3'd1]), 40));
      end
      owd_pkg::OP_LP_Z1: begin
        p0 = 80'(lpx) * 80'($signed({1'b0, lp_b0}));
        p1 = 80'(yv) * 80'(lp_a2);
        sum = 80'(owd_pkg::sat64(owd_pkg::rnd30(p0 - p1), 40));
      end
      owd_pkg::OP_BP_Y: begin
        p0 = 80'(yv) * 80'($signed({1'b0, bp_b0}));
        sum = 80'(owd_pkg::sat64(owd_pkg::rnd30(p0) + 80'(bpd[di]), 32));
      end
      owd_pkg::OP_BP_Z0: begin
        p1 = 80'(xin) * 80'(bp_a1);
        sum = 80'(owd_pkg::sat64(owd_pkg::rnd30(-p1) + 80'(bpd[di+3'd1]), 40));
      end
      owd_pkg::OP_BP_Z1: begin
        p0 = 80'(yv) * 80'($signed({1'b0, bp_b0}));
        p1 = 80'(xin) * 80'(bp_a2);
        sum = 80'(owd_pkg::sat64(owd_pkg::rnd30(-p0 - p1), 40));
      end
      owd_pkg::OP_ENC: begin
        case (cmd.comp)
          2'd0: sum = 80'(kept[0]) + 80'(kept[1]) + 80'(kept[2]) + 80'(kept[3]);
          2'd1: sum = owd_pkg::rnd30(80'(owd_pkg::ENC_Q30) *
                  (80'(kept[0]) - 80'(kept[1]) + 80'(kept[2]) - 80'(kept[3])));
          2'd2: sum = owd_pkg::rnd30(80'(owd_pkg::ENC_Q30) *
                  (80'(kept[0]) - 80'(kept[1]) - 80'(kept[2]) + 80'(kept[3])));
          default: sum = owd_pkg::rnd30(80'(owd_pkg::ENC_Q30) *
                  (80'(kept[0]) + 80'(kept[1]) - 80'(kept[2]) - 80'(kept[3])));
        endcase
        sum = 80'(owd_pkg::sat64(sum, 24));
      end
      default: ;
    endcase
  end

  // Waveshaper magnitude, divider trial and result; the middle pass negates its output.
  always_comb begin
    sv = yv;
    mag = sv[31] ? 32'(-sv) : 32'(sv);
    trial = {1'b0, rem[70:0], p_num[bidx]} - {27'd0, den};
    if (sneg) begin
      shv = (quo > 43'h80000000) ? 32'sh80000000 : 32'(-$signed({1'b0, quo}));
    end else begin
      shv = (quo > 43'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'($signed({1'b0, quo}));
    end
    if (cmd.pass == 2'd1) begin
      sgn = (shv == 32'sh80000000) ? 32'sh7FFFFFFF : -shv;
    end else begin
      sgn = shv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        lpd[i] <= '0;
        bpd[i] <= '0;
      end
      bitn <= '0;
    end else begin
      case (cmd.op)
        owd_pkg::OP_LOAD: begin
          xin <= 32'(s3);
        end
        owd_pkg::OP_LP_Y: yv <= 32'(sum);
        owd_pkg::OP_LP_Z0: lpd[di] <= 40'(sum);
        owd_pkg::OP_LP_Z1: lpd[di+3'd1] <= 40'(sum);
        owd_pkg::OP_SH_MUL: begin
          sneg <= yv[31];
          den <= 46'(21'd1 << 20) + 46'((64'(edge_k) * 64'(mag)) >> 19);
          quo <= '0;
          bitn <= 7'd72;
          // dividend numerator shifted in from MSB
          rem <= '0;
          p_num <= (72'(32'(17'h10000) + 32'(edge_k)) * 72'(mag)) << 4;
        end
        owd_pkg::OP_SH_DIV: begin
          if (!trial[72]) begin
            rem <= trial[71:0];
            quo <= {quo[41:0], 1'b1};
          end else begin
            rem <= {rem[70:0], p_num[bidx]};
            quo <= {quo[41:0], 1'b0};
          end
          bitn <= bitn - 7'd1;
        end
        owd_pkg::OP_SH_END: yv <= sgn;
        owd_pkg::OP_BP_Y: begin
          xin <= 32'(sum);
          if (cmd.first) kept[cmd.chan] <= 32'(sum);
        end
        owd_pkg::OP_BP_Z0: bpd[di] <= 40'(sum);
        owd_pkg::OP_BP_Z1: bpd[di+3'd1] <= 40'(sum);
        owd_pkg::OP_ENC: res[cmd.comp] <= 24'(sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rw <= in_w; ry <= in_y; rz <= in_z; rx <= in_x;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == owd_pkg::OP_DONE) begin
      out_w <= res[0]; out_y <= res[1]; out_z <= res[2]; out_x <= res[3];
    end
  end
endmodule

// File: hw/rtl/oversampled_waveshaper_distortion_top.sv
// Top level of the oversampled waveshaper distortion block.
// One B-format sample (W,Y,Z,X) is transferred in, decoded to four
// tetrahedral signals, each run through OVERSAMPLE zero-stuffed steps of
// lowpass biquad, triple rational waveshaper and bandpass biquad, then
// re-encoded and saturated to 24 bits. One item at a time: per channel a
// load step plus OVERSAMPLE rounds of lowpass steps, three waveshaper passes
// (each a setup, the bit-serial divide and an end step) and bandpass steps,
// then the encode steps and an output step; the bit-serial waveshaper
// divider sets nearly all of the time per item. The result is held in the
// output register until transferred; the next input is taken as soon as the
// result is registered, and a finished result waits in the output step
// while the previous one is still held.
module oversampled_waveshaper_distortion_top #(
  parameter int OVERSAMPLE = owd_pkg::OVERSAMPLE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] in_w,
  input  logic signed [23:0] in_y,
  input  logic signed [23:0] in_z,
  input  logic signed [23:0] in_x,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [23:0] out_w,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic signed [23:0] out_x
);
  owd_pkg::cmd_t  cmd;
  owd_pkg::stat_t stat;

  owd_ctrl #(.OVERSAMPLE(OVERSAMPLE)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  owd_dp #(.OVERSAMPLE(OVERSAMPLE)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_take(in_valid && !in_stall),
    .in_w, .in_y, .in_z, .in_x, .cmd, .stat,
    .out_w, .out_y, .out_z, .out_x
  );
endmodule

// File: sim/oversampled_waveshaper_distortion_top_tb.sv
// Testbench for the oversampled waveshaper distortion block: directed and random samples.
`timescale 1ns / 100ps

module oversampled_waveshaper_distortion_top_tb;
  typedef logic signed [79:0] wide_t;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [23:0] w;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [23:0] x;
  } bfmt_t;

  // Shadow of the block: coefficients, filter delays and the queue of
  // B-format samples still to come out.
  class distortion_scoreboard;
    logic [23:0] edge_k;
    wide_t lp_b0, lp_a1, lp_a2, bp_b0, bp_a1, bp_a2;
    wide_t lp_z[8];
    wide_t bp_z[8];
    bfmt_t pending_out[$];
    int fails;

    function new();
      edge_k = '0;
      lp_b0 = 0; lp_a1 = 0; lp_a2 = 0;
      bp_b0 = 0; bp_a1 = 0; bp_a2 = 0;
      foreach (lp_z[i]) begin
        lp_z[i] = 0;
        bp_z[i] = 0;
      end
      fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        owd_pkg::REG_EDGE:  edge_k = d[23:0];
        owd_pkg::REG_LP_B0: lp_b0 = wide_t'({1'b0, d[30:0]});
        owd_pkg::REG_LP_A1: lp_a1 = wide_t'($signed(d));
        owd_pkg::REG_LP_A2: lp_a2 = wide_t'($signed(d));
        owd_pkg::REG_BP_B0: bp_b0 = wide_t'({1'b0, d[30:0]});
        owd_pkg::REG_BP_A1: bp_a1 = wide_t'($signed(d));
        owd_pkg::REG_BP_A2: bp_a2 = wide_t'($signed(d));
        default: ;
      endcase
    endfunction

    function wide_t clip(wide_t v, int bits);
      wide_t lim;
      lim = wide_t'(1) <<< (bits - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // round half up from 53 to 23 fractional bits
    function wide_t round30(wide_t v);
      return (v + (wide_t'(1) <<< 29)) >>> 30;
    endfunction

    // transposed direct form II
    function wide_t biquad(wide_t x, wide_t b0, wide_t b1, wide_t b2, wide_t a1, wide_t a2,
                           inout wide_t z0, inout wide_t z1);
      wide_t yv;
      yv = clip(round30(x * b0) + z0, 32);
      z0 = clip(round30(x * b1 - yv * a1) + z1, 40);
      z1 = clip(round30(x * b2 - yv * a2), 40);
      return yv;
    endfunction

    // x(1+k)/(1+k|x|) in fixed point, saturated to 32 bits
    function wide_t shaper(wide_t x);
      logic [63:0] mag, den, q, k;
      k = 64'(edge_k);
      mag = (x < 0) ? 64'(-x) : 64'(x);
      den = (64'd1 << 20) + ((k * mag) >> 19);
      q = (((64'd1 << 16) + k) * mag * 64'd16) / den;
      if (x < 0) begin
        if (q > (64'd1 << 31)) q = 64'd1 << 31;
        return -wide_t'(q);
      end
      if (q > (64'd1 << 31) - 1) q = (64'd1 << 31) - 1;
      return wide_t'(q);
    endfunction

    function void note_input(bfmt_t s);
      wide_t w, y, z, x, sum, a, v;
      wide_t kept[4];
      wide_t enc1, enc2, enc3;
      bfmt_t res;
      int sy, sz, sx;
      w = s.w; y = s.y; z = s.z; x = s.x;
      for (int c = 0; c < owd_pkg::CHANNELS; c++) begin
        sy = (c[0] == 1'b0) ? 1 : -1;
        sz = (c == 0 || c == 3) ? 1 : -1;
        sx = (c < 2) ? 1 : -1;
        sum = w * (wide_t'(1) <<< 28) +
              wide_t'(owd_pkg::DEC_Q30) * (sy * y + sz * z + sx * x);
        a = (sum * owd_pkg::OVERSAMPLE + (wide_t'(1) <<< 29)) >>> 30;
        for (int i = 0; i < owd_pkg::OVERSAMPLE; i++) begin
          v = biquad((i == 0) ? a : wide_t'(0), lp_b0, 2 * lp_b0, lp_b0, lp_a1, lp_a2,
                     lp_z[2*c], lp_z[2*c+1]);
          v = shaper(v);
          v = clip(-shaper(v), 32);
          v = shaper(v);
          v = biquad(v, bp_b0, 0, -bp_b0, bp_a1, bp_a2, bp_z[2*c], bp_z[2*c+1]);
          if (i == 0) kept[c] = v;
        end
      end
      enc1 = round30(wide_t'(owd_pkg::ENC_Q30) * (kept[0] - kept[1] + kept[2] - kept[3]));
      enc2 = round30(wide_t'(owd_pkg::ENC_Q30) * (kept[0] - kept[1] - kept[2] + kept[3]));
      enc3 = round30(wide_t'(owd_pkg::ENC_Q30) * (kept[0] + kept[1] - kept[2] - kept[3]));
      res.w = 24'(clip(kept[0] + kept[1] + kept[2] + kept[3], 24));
      res.y = 24'(clip(enc1, 24));
      res.z = 24'(clip(enc2, 24));
      res.x = 24'(clip(enc3, 24));
      pending_out.push_back(res);
    endfunction

    function void check_output(bfmt_t got);
      bfmt_t exp_s;
      if (pending_out.size() == 0) begin
        $error("output transfer with nothing outstanding");
        fails++;
        return;
      end
      exp_s = pending_out.pop_front();
      if (got.w !== exp_s.w) begin
        $error("out_w expected %0d got %0d", exp_s.w, got.w); fails++;
      end
      if (got.y !== exp_s.y) begin
        $error("out_y expected %0d got %0d", exp_s.y, got.y); fails++;
      end
      if (got.z !== exp_s.z) begin
        $error("out_z expected %0d got %0d", exp_s.z, got.z); fails++;
      end
      if (got.x !== exp_s.x) begin
        $error("out_x expected %0d got %0d", exp_s.x, got.x); fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [23:0] in_w, in_y, in_z, in_x;
  logic out_valid;
  logic out_stall;
  logic signed [23:0] out_w, out_y, out_z, out_x;

  distortion_scoreboard sb;
  bit calm;        // no random idling on either side
  bit hold_req;    // ask the receiver for one long hold-off

  oversampled_waveshaper_distortion_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_w(in_w), .in_y(in_y), .in_z(in_z), .in_x(in_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_w(out_w), .out_y(out_y), .out_z(out_z), .out_x(out_x)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // block fills up and pushes back on its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (20000) @(negedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  // Output monitor: a transfer happens when valid is high and stall low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_output('{out_w, out_y, out_z, out_x});
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain();
    while (sb.pending_out.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_coeffs(logic [31:0] ek, logic [31:0] lb, logic [31:0] la1,
                             logic [31:0] la2, logic [31:0] bb, logic [31:0] ba1,
                             logic [31:0] ba2);
    drain();
    write_cfg(owd_pkg::REG_EDGE, ek);
    write_cfg(owd_pkg::REG_LP_B0, lb);
    write_cfg(owd_pkg::REG_LP_A1, la1);
    write_cfg(owd_pkg::REG_LP_A2, la2);
    write_cfg(owd_pkg::REG_BP_B0, bb);
    write_cfg(owd_pkg::REG_BP_A1, ba1);
    write_cfg(owd_pkg::REG_BP_A2, ba2);
  endtask

  // Sender is left at a falling edge with valid still high; gaps lower it.
  task automatic send_sample(bfmt_t s);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_w <= s.w; in_y <= s.y; in_z <= s.z; in_x <= s.x;
    do @(posedge clk); while (in_stall);
    sb.note_input(s);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] pick_field(int mode);
    case (mode)
      0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      1: return 24'($signed($urandom_range(131071)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_samples(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(3);
      send_sample('{pick_field(mode), pick_field(mode), pick_field(mode), pick_field(mode)});
    end
  endtask

  task automatic close_phase();
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    {in_w, in_y, in_z, in_x} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset coefficients: everything should come out zero.
    send_sample('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
    send_sample('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000});
    close_phase();

    // Directed, a plausible drive setting: k = 1, stable filters.
    load_coeffs(32'd65536, 32'd107374182, -32'sd1181116006, 32'sd429496730,
                32'd214748365, -32'sd1610612736, 32'sd644245094);
    write_cfg(REG_UNMAPPED, 32'hFFFFFFFF);  // unmapped index, must be ignored
    send_sample('{24'sd0, 24'sd0, 24'sd0, 24'sd0});
    send_sample('{24'sh7FFFFF, 24'sd0, 24'sd0, 24'sd0});
    send_sample('{24'sh800000, 24'sd0, 24'sd0, 24'sd0});
    send_sample('{24'sd0, 24'sh7FFFFF, 24'sd0, 24'sd0});
    send_sample('{24'sd0, 24'sd0, 24'sh800000, 24'sd0});
    send_sample('{24'sd0, 24'sd0, 24'sd0, 24'sh7FFFFF});
    send_sample('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
    send_sample('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000});
    send_sample('{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000});
    send_sample('{24'sd1, -24'sd1, 24'sd1, -24'sd1});
    close_phase();

    // Directed, hardest edge and unstable filters so outputs and delays saturate.
    load_coeffs(32'd12976128, 32'd1073741824, 32'h80000000, 32'h7FFFFFFF,
                32'd1073741824, 32'h7FFFFFFF, 32'h80000000);
    for (int i = 0; i < 6; i++)
      send_sample('{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000});
    send_sample('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000});
    send_sample('{24'sd0, 24'sd0, 24'sd0, 24'sd0});
    close_phase();

    // Random: typical setting, no idling at all.
    load_coeffs(32'd327680, 32'd53687091, -32'sd1717986918, 32'sd751619277,
                32'd161061274, -32'sd1825361101, 32'sd858993459);
    calm = 1'b1;
    random_samples(100);
    close_phase();
    calm = 1'b0;

    // Random: edge beyond its range, all-ones b0, with a long output hold-off.
    load_coeffs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    hold_req = 1'b1;
    random_samples(100);
    close_phase();

    // Random: zero edge (waveshaper passes through), mild filters.
    load_coeffs(32'd0, 32'd268435456, -32'sd536870912, 32'sd134217728,
                32'd268435456, -32'sd1073741824, 32'sd268435456);
    random_samples(100);
    close_phase();

    // Random coefficient sets.
    for (int p = 0; p < 2; p++) begin
      load_coeffs($urandom_range(12976128), $urandom_range(1073741824), $urandom,
                  $urandom, $urandom_range(1073741824), $urandom, $urandom);
      random_samples(100);
      close_phase();
    end

    if (sb.fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
